[src/ipat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipat_pkg
// Shared types, character codes and digit helpers for the address formatter.
// ----------------------------------------------------------------------------
package ipat_pkg;

  typedef struct packed {
    logic        family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } addr_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } char_t;

  typedef enum logic [2:0] {
    CK_COLON,
    CK_DOT,
    CK_HEX,
    CK_DEC,
    CK_F
  } char_kind_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    char_kind_t kind;
    logic [2:0] word;
    logic [1:0] nib;
    logic [1:0] oct;
    logic [1:0] pos;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic            busy;
    logic            family;
    logic            embed;
    logic            embed_ffff;
    logic            run_valid;
    logic [2:0]      run_start;
    logic [3:0]      run_end;
    logic [7:0][1:0] lead;
    logic [3:0][1:0] ndig;
  } stat_t;

  localparam logic [6:0] ASC_COLON = 7'h3a;
  localparam logic [6:0] ASC_DOT   = 7'h2e;
  localparam logic [6:0] ASC_ZERO  = 7'h30;
  localparam logic [6:0] ASC_LOW_A = 7'h61;
  localparam logic [6:0] ASC_LOW_F = 7'h66;
  localparam logic [3:0] WORDS     = 4'd8;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) c = ASC_ZERO + {3'b000, d};
    else c = ASC_LOW_A + {3'b000, d} - 7'd10;
    return c;
  endfunction

  function automatic logic [1:0] lead_nib(input logic [15:0] w);
    logic [1:0] l;
    if (w[15:12] != 4'h0) l = 2'd3;
    else if (w[11:8] != 4'h0) l = 2'd2;
    else if (w[7:4] != 4'h0) l = 2'd1;
    else l = 2'd0;
    return l;
  endfunction

  // digit position: 2 hundreds, 1 tens, 0 units
  function automatic logic [1:0] dec_ndig(input logic [7:0] v);
    logic [1:0] n;
    if (v >= 8'd100) n = 2'd3;
    else if (v >= 8'd10) n = 2'd2;
    else n = 2'd1;
    return n;
  endfunction

  function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] t;
    logic [6:0] u;
    logic [3:0] d;
    h = (v >= 8'd200) ? 2'd2 : (v >= 8'd100) ? 2'd1 : 2'd0;
    r = (h == 2'd2) ? v - 8'd200 : (h == 2'd1) ? v - 8'd100 : v;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(10 * k)) t = 4'(k);
    end
    u = r[6:0] - {t, 3'b000} - {2'b00, t, 1'b0};
    if (pos == 2'd2) d = {2'b00, h};
    else if (pos == 2'd1) d = t;
    else d = u[3:0];
    return d;
  endfunction

endpackage

[src/ip_address_text_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_formatter
// Prints a binary IPv4/IPv6 address, one character a cycle unless stalled.
// ----------------------------------------------------------------------------
// addr channel: addr_valid/addr_stall carry one address transaction (family,
// addr_hi, addr_lo). addr_stall is high while an address is being printed.
// text channel: char_valid/char_stall carry one ASCII character per
// transaction, last_char marks the final character of an address.
// The address is registered when taken; the sequencer reads the analysis in
// its first state and then issues one character per cycle into the output
// register while the text channel does not stall. Each address gives 2 to
// 39 characters.
// A stall on the text channel holds the character in the output register and
// freezes the sequencer; nothing is dropped.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
// ----------------------------------------------------------------------------
module ip_address_text_formatter import ipat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  addr_valid,
  output logic  addr_stall,
  input  addr_t addr,
  output logic  char_valid,
  input  logic  char_stall,
  output char_t text
);

  cmd_t  cmd;
  stat_t stat;
  logic  idle;

  assign addr_stall = !idle;

  ipat_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (addr_valid && !addr_stall),
    .stat   (stat),
    .idle   (idle),
    .cmd    (cmd)
  );

  ipat_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .addr       (addr),
    .cmd        (cmd),
    .stat       (stat),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .text       (text)
  );

endmodule

[src/ipat_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipat_dp
// Address registers, zero-run and digit analysis, and the character output
// register.
// ----------------------------------------------------------------------------
module ipat_dp import ipat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  addr_t addr,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  char_valid,
  input  logic  char_stall,
  output char_t text
);

  logic [7:0][15:0] w;
  logic [7:0][15:0] aw;
  logic [3:0][7:0]  oc;
  logic [7:0]       zin;
  logic [3:0]       cnt;
  logic [3:0]       blen;
  logic [3:0]       bend;
  logic [2:0]       bstart;
  logic             found;
  logic             embed_next;
  stat_t            info;
  logic [15:0]      cur_word;
  logic [3:0]       cur_nib;
  logic [6:0]       ch;

  assign aw = {addr.addr_hi, addr.addr_lo};

  always_comb begin
    cnt    = 4'd0;
    blen   = 4'd1;
    bend   = 4'd0;
    bstart = 3'd0;
    found  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      zin[i] = aw[3'(7 - i)] == 16'h0000;
    end
    for (int i = 0; i < 8; i++) begin
      if (zin[i]) begin
        cnt = cnt + 4'd1;
        if (cnt > blen) begin
          blen   = cnt;
          bend   = 4'(i + 1);
          bstart = 3'(4'(i + 1) - cnt);
          found  = 1'b1;
        end
      end else begin
        cnt = 4'd0;
      end
    end
  end

  assign embed_next = (addr.addr_hi == 64'd0) && (addr.addr_lo[63:48] == 16'h0000)
    && ((addr.addr_lo[47:32] == 16'hffff)
        || ((addr.addr_lo[47:32] == 16'h0000) && (addr.addr_lo[31:16] != 16'h0000)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w               <= {addr.addr_hi, addr.addr_lo};
      oc              <= addr.addr_lo[31:0];
      info.busy       <= 1'b0;
      info.family     <= addr.family;
      info.embed      <= embed_next;
      info.embed_ffff <= addr.addr_lo[47:32] != 16'h0000;
      info.run_valid  <= found;
      info.run_start  <= bstart;
      info.run_end    <= bend;
      for (int i = 0; i < 8; i++) begin
        info.lead[i] <= lead_nib(addr.addr_hi[63:0] == 64'd0 && i < 4 ? 16'h0000 :
                        16'(({addr.addr_hi, addr.addr_lo} >> (16 * (7 - i)))));
      end
      for (int o = 0; o < 4; o++) begin
        info.ndig[o] <= dec_ndig(8'(addr.addr_lo >> (8 * (3 - o))));
      end
    end
  end

  assign cur_word = w[3'd7 - cmd.word];
  assign cur_nib  = 4'(cur_word >> {cmd.nib, 2'b00});

  always_comb begin
    unique case (cmd.kind)
      CK_COLON: ch = ASC_COLON;
      CK_DOT:   ch = ASC_DOT;
      CK_HEX:   ch = hex_char(cur_nib);
      CK_DEC:   ch = ASC_ZERO + {3'b000, dec_digit(oc[2'd3 - cmd.oct], cmd.pos)};
      CK_F:     ch = ASC_LOW_F;
      default:  ch = ASC_COLON;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (cmd.emit) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      text.text_char <= ch;
      text.last_char <= cmd.last;
    end
  end

  always_comb begin
    stat      = info;
    stat.busy = char_valid && char_stall;
  end

endmodule

[src/ipat_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipat_ctrl
// Sequencer that walks the address text, one character per unstalled cycle.
// ----------------------------------------------------------------------------
module ipat_ctrl import ipat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  stat_t stat,
  output logic  idle,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_E_C1, S_E_C2, S_E_F, S_E_C3,
    S_W_HEAD, S_W_SEP, S_W_HEX, S_W_END, S_DEC, S_DOT
  } state_t;

  state_t     state;
  logic [2:0] wi;
  logic [1:0] nib;
  logic [1:0] oct;
  logic [1:0] pos;
  logic [1:0] fcnt;
  logic       go;
  logic       at_run;

  assign idle   = state == S_IDLE;
  assign go     = !stat.busy;
  assign at_run = stat.run_valid && (wi == stat.run_start);

  always_comb begin
    cmd      = '0;
    cmd.load = idle && accept;
    cmd.word = wi;
    cmd.nib  = nib;
    cmd.oct  = oct;
    cmd.pos  = pos;
    cmd.kind = CK_COLON;
    unique case (state)
      S_IDLE, S_FIRST: cmd.emit = 1'b0;
      S_E_C1, S_E_C2, S_E_C3, S_W_HEAD, S_W_SEP: cmd.emit = go;
      S_W_END: begin
        cmd.emit = go;
        cmd.last = 1'b1;
      end
      S_E_F: begin
        cmd.emit = go;
        cmd.kind = CK_F;
      end
      S_W_HEX: begin
        cmd.emit = go;
        cmd.kind = CK_HEX;
        cmd.last = (wi == 3'd7) && (nib == 2'd0);
      end
      S_DEC: begin
        cmd.emit = go;
        cmd.kind = CK_DEC;
        cmd.last = (oct == 2'd3) && (pos == 2'd0);
      end
      S_DOT: begin
        cmd.emit = go;
        cmd.kind = CK_DOT;
      end
      default: cmd.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_FIRST;
        S_FIRST: begin
          wi <= 3'd0;
          if (!stat.family) begin
            oct   <= 2'd0;
            pos   <= stat.ndig[0] - 2'd1;
            state <= S_DEC;
          end else if (stat.embed) begin
            state <= S_E_C1;
          end else if (stat.run_valid && stat.run_start == 3'd0) begin
            state <= S_W_HEAD;
          end else begin
            nib   <= stat.lead[0];
            state <= S_W_HEX;
          end
        end
        S_E_C1: if (go) state <= S_E_C2;
        S_E_C2: if (go) begin
          fcnt <= 2'd0;
          oct  <= 2'd0;
          pos  <= stat.ndig[0] - 2'd1;
          state <= stat.embed_ffff ? S_E_F : S_DEC;
        end
        S_E_F: if (go) begin
          fcnt <= fcnt + 2'd1;
          if (fcnt == 2'd3) state <= S_E_C3;
        end
        S_E_C3: if (go) state <= S_DEC;
        S_W_HEAD: if (go) begin
          if (at_run) begin
            wi    <= stat.run_end[2:0];
            state <= (stat.run_end == WORDS) ? S_W_END : S_W_SEP;
          end else begin
            nib   <= stat.lead[wi];
            state <= S_W_HEX;
          end
        end
        S_W_SEP: if (go) begin
          nib   <= stat.lead[wi];
          state <= S_W_HEX;
        end
        S_W_HEX: if (go) begin
          if (nib == 2'd0) begin
            if (wi == 3'd7) begin
              state <= S_IDLE;
            end else begin
              wi    <= wi + 3'd1;
              state <= S_W_HEAD;
            end
          end else begin
            nib <= nib - 2'd1;
          end
        end
        S_W_END: if (go) state <= S_IDLE;
        S_DEC: if (go) begin
          if (pos == 2'd0) state <= (oct == 2'd3) ? S_IDLE : S_DOT;
          else pos <= pos - 2'd1;
        end
        S_DOT: if (go) begin
          oct   <= oct + 2'd1;
          pos   <= stat.ndig[oct + 2'd1] - 2'd1;
          state <= S_DEC;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.busy) else $error("character issued into a held output");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    (idle && accept) |=> state == S_FIRST) else $error("accepted address not started");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> idle) else $error("sequencer busy after last character");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds IPv4 and IPv6 addresses to the formatter and compares every emitted
// character and its last flag with text built by an address printer here.
// ----------------------------------------------------------------------------
import ipat_pkg::*;

class text_board;
  char_t pending[$];
  int errors;

  function void put_ch(byte c);
    char_t t;
    t.text_char = c[6:0];
    t.last_char = 1'b0;
    pending = {pending, t};
  endfunction

  function void put_dec(logic [7:0] v);
    if (v >= 100) put_ch(8'(8'h30 + v / 100));
    if (v >= 10) put_ch(8'(8'h30 + (v / 10) % 10));
    put_ch(8'(8'h30 + v % 10));
  endfunction

  function void put_hex(logic [15:0] v);
    logic started;
    logic [3:0] d;
    started = 0;
    for (int sh = 12; sh >= 0; sh -= 4) begin
      d = v[sh +: 4];
      if (d != 0 || started || sh == 0) begin
        put_ch(8'(d < 10 ? 8'h30 + d : 8'h61 + d - 10));
        started = 1;
      end
    end
  endfunction

  function void put_v4(logic [31:0] a);
    put_dec(a[31:24]); put_ch(".");
    put_dec(a[23:16]); put_ch(".");
    put_dec(a[15:8]); put_ch(".");
    put_dec(a[7:0]);
  endfunction

  function void note_addr(addr_t a);
    logic [15:0] w[8];
    int i, cnt, run_len, run_first;
    int first;
    first = pending.size();
    for (i = 0; i < 8; i++)
      w[i] = (i < 4) ? a.addr_hi[(3 - i) * 16 +: 16] : a.addr_lo[(7 - i) * 16 +: 16];
    if (!a.family) begin
      put_v4(a.addr_lo[31:0]);
    end else if (a.addr_hi == 0) begin
      put_ch(":");
      if (w[4] == 0 && (w[5] == 16'hffff || (w[5] == 0 && w[6] != 0))) begin
        if (w[5] != 0) begin
          put_ch(":"); put_hex(16'hffff);
        end
        put_ch(":");
        put_v4(a.addr_lo[31:0]);
      end else begin
        i = 4;
        while (i < 8 && w[i] == 0) i++;
        if (i == 8) put_ch(":");
        for (; i < 8; i++) begin
          put_ch(":"); put_hex(w[i]);
        end
      end
    end else begin
      cnt = 0; run_len = 1; run_first = -1;
      for (i = 0; i < 8; i++) begin
        if (w[i] == 0) begin
          cnt++;
          if (cnt > run_len) begin
            run_len = cnt; run_first = i + 1 - cnt;
          end
        end else cnt = 0;
      end
      i = 0;
      while (i < 8) begin
        if (i == run_first) begin
          i += 2;
          while (i < 8 && w[i] == 0) i++;
          put_ch(":");
          if (i >= 8) begin
            put_ch(":");
            break;
          end
        end
        if (i != 0) put_ch(":");
        put_hex(w[i]);
        i++;
      end
    end
    while (pending.size() - first > 39) void'(pending.pop_back());
    pending[pending.size() - 1].last_char = 1'b1;
  endfunction

  function void check_char(char_t got);
    char_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected char %h last %b", $time, got.text_char, got.last_char);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.text_char != exp.text_char) begin
      $display("%0t: text_char expected %h actual %h", $time, exp.text_char, got.text_char);
      errors++;
    end
    if (got.last_char != exp.last_char) begin
      $display("%0t: last_char expected %b actual %b", $time, exp.last_char, got.last_char);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst = 1;
  logic addr_valid = 0;
  logic addr_stall;
  addr_t addr = '0;
  logic char_valid;
  logic char_stall = 0;
  char_t text;
  text_board board = new();
  int hold_off = 0;

  ip_address_text_formatter u_dut (.*);

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1: return 16'h0;
      2: return 16'hffff;
      3: return 16'h1 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(addr_t a);
    int n;
    addr_valid <= 1;
    addr <= a;
    do @(posedge clk); while (addr_stall);
    board.note_addr(a);
    n = gap_len();
    if (n > 0) begin
      addr_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    addr_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send6(logic [15:0] w0, w1, w2, w3, w4, w5, w6, w7);
    send({1'b1, w0, w1, w2, w3, w4, w5, w6, w7});
  endtask

  task automatic send_rand();
    addr_t a;
    a.family = $urandom_range(0, 3) != 0;
    for (int i = 0; i < 4; i++) a.addr_hi[i * 16 +: 16] = rand_word();
    for (int i = 0; i < 4; i++) a.addr_lo[i * 16 +: 16] = rand_word();
    case ($urandom_range(0, 5))
      0: a.addr_hi = 0;
      1: begin
        a.addr_hi = 0; a.addr_lo[63:48] = 0;
        a.addr_lo[47:32] = $urandom_range(0, 1) ? 16'hffff : 16'h0;
      end
      2: a.addr_lo[31:0] = $urandom;
      default: ;
    endcase
    send(a);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall) board.check_char(text);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      char_stall <= 1;
    end else begin
      char_stall <= ($urandom_range(0, 99) < 25) || ($urandom_range(0, 199) == 0);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send({1'b0, 64'h0, 64'h0});
    send({1'b0, 64'hffffffffffffffff, 64'hffffffffffffffff});
    send({1'b0, 64'h0, 64'h0a09_6301});
    send6(0, 0, 0, 0, 0, 0, 0, 0);
    send6(0, 0, 0, 0, 0, 0, 0, 1);
    send6(0, 0, 0, 0, 0, 16'hffff, 16'hc0a8, 16'h0001);
    send6(0, 0, 0, 0, 0, 0, 16'h0102, 16'h0304);
    send6(0, 0, 0, 0, 0, 0, 0, 16'h0304);
    send6(0, 0, 0, 0, 16'h0, 16'hfffe, 16'h1, 16'h2);
    send6(0, 0, 0, 0, 16'h1, 0, 0, 0);
    send6(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send6(16'h2001, 16'hdb8, 0, 0, 1, 0, 0, 1);
    send6(16'h2001, 0, 1, 0, 0, 0, 0, 0);
    send6(16'h1, 0, 16'h1, 0, 16'h1, 0, 16'h1, 0);
    send6(0, 0, 0, 16'h1, 16'h1, 0, 0, 0);
    send6(16'h1, 0, 0, 0, 0, 0, 0, 0);
    send6(16'h0, 16'h0, 16'h0, 16'h1, 0, 0, 0, 1);
    send6(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'h10, 16'h100, 16'h1000, 16'h0);
    send({1'b1, 64'h0, 64'h0000_ffff_ffff_ffff});
    // hold the receiver off while addresses keep coming
    hold_off = 300;
    for (int k = 0; k < 5; k++) send_rand();
    // drain before continuing
    drain();
    for (int k = 0; k < 125; k++) send_rand();
    drain();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end
endmodule
